// ===== rtl/core/jse_pkg.sv =====
// ----------------------------------------------------------------------------
// jse_pkg
// Shared types, token codes and character helpers for the JSON string
// escaper: the per-item token plan handed from the planner to the emitter.
// ----------------------------------------------------------------------------
package jse_pkg;

    // Token kinds: how one planned token expands into output characters
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_RAW  = 2'd0;   // one character, the byte itself
    localparam t_kind KIND_ESC2 = 2'd1;   // backslash + letter
    localparam t_kind KIND_HEX  = 2'd2;   // \u00xx, lowercase hex

    // Fixed token slots of one item, in output order
    localparam int NUM_SLOTS   = 9;
    localparam int SLOT_OPEN   = 0;       // opening quote
    localparam int SLOT_PEND0  = 1;       // held bytes, passed or escaped (3 slots)
    localparam int SLOT_NEW    = 4;       // the item's own byte
    localparam int SLOT_FLUSH0 = 5;       // held bytes escaped at end of string (3 slots)
    localparam int SLOT_CLOSE  = 8;       // closing quote
    localparam int PEND_DEPTH  = 3;

    // Characters used in the escaped text
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // Sub-character positions inside a token
    localparam logic [2:0] SUB_ESC2_LAST = 3'd1;
    localparam logic [2:0] SUB_HEX_LAST  = 3'd5;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_tok;

    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        t_tok [NUM_SLOTS-1:0] tok;
    } t_plan;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       has_byte;
        logic       first_item;
        logic       last_item;
    } t_item;

    // Lowercase hex digit
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = 8'h30 + {4'h0, nib};
        end else begin
            c = 8'h57 + {4'h0, nib};
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/jse_plan.sv =====
// ----------------------------------------------------------------------------
// jse_plan
// Owns the pending UTF-8 store and turns one item into a fixed token plan.
// State moves on only when the emitter takes the plan.
// ----------------------------------------------------------------------------
module jse_plan
    import jse_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_item i_item,
    input  logic  i_load,
    output t_plan o_plan
);

    logic [7:0] r_pb [PEND_DEPTH];
    logic [1:0] r_pc;
    logic [2:0] r_sl;

    logic [7:0] n_pb [PEND_DEPTH];
    logic [1:0] n_pc;
    logic [2:0] n_sl;

    // Planning: quote, take byte, end-of-string flush
    always_comb begin
        logic       do_fresh;
        logic       fits;
        logic [7:0] b;
        t_plan      p;

        b        = i_item.in_byte;
        n_pb     = r_pb;
        n_pc     = r_pc;
        n_sl     = r_sl;
        do_fresh = 1'b0;
        fits     = 1'b0;
        p.mask   = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            p.tok[k] = '{kind: KIND_RAW, data: CH_QUOTE};
        end

        // opening quote drops anything held
        if (i_item.first_item) begin
            n_pc = 2'd0;
            n_sl = 3'd0;
            p.mask[SLOT_OPEN] = 1'b1;
        end

        if (i_item.has_byte) begin
            // continuation check, with the tight second-byte ranges
            fits = (b[7:6] == 2'b10);
            if (n_pc == 2'd1) begin
                if (n_pb[0] == 8'hE0 && b <  8'hA0) fits = 1'b0;
                if (n_pb[0] == 8'hED && b >= 8'hA0) fits = 1'b0;
                if (n_pb[0] == 8'hF0 && b <  8'h90) fits = 1'b0;
                if (n_pb[0] == 8'hF4 && b >= 8'h90) fits = 1'b0;
            end

            if (n_pc == 2'd0 || n_sl < 3'd2) begin
                do_fresh = 1'b1;
            end else if (!fits) begin
                // broken sequence: escape held bytes, restart on this one
                for (int k = 0; k < PEND_DEPTH; k++) begin
                    if (k < int'(n_pc)) begin
                        p.mask[SLOT_PEND0+k] = 1'b1;
                        p.tok[SLOT_PEND0+k]  = '{kind: KIND_HEX, data: n_pb[k]};
                    end
                end
                n_pc     = 2'd0;
                n_sl     = 3'd0;
                do_fresh = 1'b1;
            end else if (({1'b0, n_pc} + 3'd1 >= n_sl) || n_pc == 2'd3) begin
                // sequence complete: pass it through unchanged
                for (int k = 0; k < PEND_DEPTH; k++) begin
                    if (k < int'(n_pc)) begin
                        p.mask[SLOT_PEND0+k] = 1'b1;
                        p.tok[SLOT_PEND0+k]  = '{kind: KIND_RAW, data: n_pb[k]};
                    end
                end
                p.mask[SLOT_NEW] = 1'b1;
                p.tok[SLOT_NEW]  = '{kind: KIND_RAW, data: b};
                n_pc = 2'd0;
                n_sl = 3'd0;
            end else begin
                // hold the continuation byte
                for (int k = 0; k < PEND_DEPTH; k++) begin
                    if (k == int'(n_pc)) n_pb[k] = b;
                end
                n_pc = n_pc + 2'd1;
            end
        end

        // byte with nothing pending
        if (do_fresh) begin
            p.mask[SLOT_NEW] = 1'b1;
            case (b)
                8'h22:   p.tok[SLOT_NEW] = '{kind: KIND_ESC2, data: 8'h22};
                8'h5C:   p.tok[SLOT_NEW] = '{kind: KIND_ESC2, data: 8'h5C};
                8'h08:   p.tok[SLOT_NEW] = '{kind: KIND_ESC2, data: 8'h62};
                8'h0C:   p.tok[SLOT_NEW] = '{kind: KIND_ESC2, data: 8'h66};
                8'h0A:   p.tok[SLOT_NEW] = '{kind: KIND_ESC2, data: 8'h6E};
                8'h0D:   p.tok[SLOT_NEW] = '{kind: KIND_ESC2, data: 8'h72};
                8'h09:   p.tok[SLOT_NEW] = '{kind: KIND_ESC2, data: 8'h74};
                default: begin
                    if (b < 8'h20) begin
                        p.tok[SLOT_NEW] = '{kind: KIND_HEX, data: b};
                    end else if (b < 8'h80) begin
                        p.tok[SLOT_NEW] = '{kind: KIND_RAW, data: b};
                    end else if (b inside {[8'hC2:8'hF4]}) begin
                        // lead byte: start a pending sequence, no output yet
                        p.mask[SLOT_NEW] = 1'b0;
                        n_pb[0] = b;
                        n_pc    = 2'd1;
                        n_sl    = (b < 8'hE0) ? 3'd2 : ((b < 8'hF0) ? 3'd3 : 3'd4);
                    end else begin
                        p.tok[SLOT_NEW] = '{kind: KIND_HEX, data: b};
                    end
                end
            endcase
        end

        // end of string: escape a cut-off sequence, then close
        if (i_item.last_item) begin
            for (int k = 0; k < PEND_DEPTH; k++) begin
                if (k < int'(n_pc)) begin
                    p.mask[SLOT_FLUSH0+k] = 1'b1;
                    p.tok[SLOT_FLUSH0+k]  = '{kind: KIND_HEX, data: n_pb[k]};
                end
            end
            p.mask[SLOT_CLOSE] = 1'b1;
            n_pc = 2'd0;
            n_sl = 3'd0;
        end

        o_plan = p;
    end

    // Pending store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= 2'd0;
            r_sl <= 3'd0;
            for (int k = 0; k < PEND_DEPTH; k++) r_pb[k] <= 8'h00;
        end else if (i_load) begin
            r_pc <= n_pc;
            r_sl <= n_sl;
            r_pb <= n_pb;
        end
    end

endmodule

// ===== rtl/core/jse_emit.sv =====
// ----------------------------------------------------------------------------
// jse_emit
// Walks a loaded token plan into the output register, lowest slot first,
// one character per cycle unless stalled. Reports when it can take a plan.
// ----------------------------------------------------------------------------
module jse_emit
    import jse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_plan      i_plan,
    input  logic       i_load,
    output logic       o_free,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,
    output logic       o_m_tlast
);

    logic [NUM_SLOTS-1:0] r_mask;
    t_tok [NUM_SLOTS-1:0] r_tok;
    logic [2:0]           r_sub;
    logic                 r_out_valid;
    logic [7:0]           r_out_char;
    logic                 r_out_last;

    logic [NUM_SLOTS-1:0] sel_oh;
    logic [NUM_SLOTS-1:0] rest_mask;
    t_tok                 cur;
    logic                 tok_done;
    logic [7:0]           cur_char;
    logic                 cur_last;
    logic                 go;
    logic                 advance;

    // Lowest pending slot and its current character
    always_comb begin
        sel_oh    = r_mask & (~r_mask + {{(NUM_SLOTS-1){1'b0}}, 1'b1});
        rest_mask = r_mask & ~sel_oh;
        cur       = '0;
        for (int k = 0; k < NUM_SLOTS; k++) begin
            if (sel_oh[k]) cur = r_tok[k];
        end
        case (cur.kind)
            KIND_RAW: begin
                tok_done = 1'b1;
                cur_char = cur.data;
            end
            KIND_ESC2: begin
                tok_done = (r_sub == SUB_ESC2_LAST);
                cur_char = (r_sub == 3'd0) ? CH_BSLASH : cur.data;
            end
            KIND_HEX: begin
                tok_done = (r_sub == SUB_HEX_LAST);
                case (r_sub)
                    3'd0:    cur_char = CH_BSLASH;
                    3'd1:    cur_char = CH_U;
                    3'd4:    cur_char = hex_digit(cur.data[7:4]);
                    3'd5:    cur_char = hex_digit(cur.data[3:0]);
                    default: cur_char = CH_ZERO;
                endcase
            end
            default: begin
                tok_done = 1'b1;
                cur_char = cur.data;
            end
        endcase
        cur_last = tok_done && (rest_mask == '0);
    end

    assign go      = !r_out_valid || i_m_tready;
    assign advance = go && (r_mask != '0);
    assign o_free  = (r_mask == '0) || (advance && cur_last);

    // Token walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_sub  <= 3'd0;
        end else if (i_load) begin
            r_mask <= i_plan.mask;
            r_tok  <= i_plan.tok;
            r_sub  <= 3'd0;
        end else if (advance) begin
            if (tok_done) begin
                r_mask <= rest_mask;
                r_sub  <= 3'd0;
            end else begin
                r_sub  <= r_sub + 3'd1;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go) begin
            r_out_valid <= advance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_char <= cur_char;
            r_out_last <= cur_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== rtl/core/json_string_escape_utf8.sv =====
// ----------------------------------------------------------------------------
// json_string_escape_utf8
// Raw string bytes in, quoted JSON text out, with strict UTF-8 checking.
//
//   channel | dir | tdata               | tuser                      | tlast
//   s       | in  | [7:0] in_byte       | [0] has_byte, [1] first    | last_item
//   m       | out | [7:0] out_char      | -                          | last_char
//
// An item is held in the input register until it is planned and loaded
// into the emitter, which puts out one character per cycle while the output
// is not stalled: one character per item for plain ASCII, up to 25 for the
// widest escape expansion. The emitter takes the next plan in the cycle its
// last character leaves, so single-character items stream at one per cycle
// while the output is not stalled. A stall on the output holds the output
// register and backs up through the emitter into the input register. Reset
// clears the pending store and all valid flags.
// ----------------------------------------------------------------------------
module json_string_escape_utf8
    import jse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic [1:0] i_s_tuser,   // [0] has_byte, [1] first_item
    input  logic       i_s_tlast,   // last_item
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_char
    output logic       o_m_tlast    // last_char
);

    logic  r_in_valid;
    t_item r_in;
    logic  emit_free;
    logic  load;
    t_plan plan;

    assign load       = r_in_valid && emit_free;
    assign o_s_tready = !r_in_valid || load;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in.in_byte    <= i_s_tdata;
            r_in.has_byte   <= i_s_tuser[0];
            r_in.first_item <= i_s_tuser[1];
            r_in.last_item  <= i_s_tlast;
        end
    end

    jse_plan u_plan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (r_in),
        .i_load  (load),
        .o_plan  (plan)
    );

    jse_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_plan     (plan),
        .i_load     (load),
        .o_free     (emit_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== rtl/core/jse_checker.sv =====
// ----------------------------------------------------------------------------
// jse_checker
// Port-level checks on the escaper's streams, bound to the top level.
// ----------------------------------------------------------------------------
module jse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tlast))
        else $error("output beat changed under stall");

    // control characters below 0x20 never reach the JSON text
    a_no_ctrl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata >= 8'h20)
        else $error("raw control character in output");

    // a valid output beat carries known data
    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !$isunknown({o_m_tdata, o_m_tlast}))
        else $error("unknown value on a valid output beat");

    // reset empties the output register
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // reset empties the input register, so the input side is ready
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready)
        else $error("input not ready after reset");

endmodule

bind json_string_escape_utf8 jse_checker u_jse_checker (.*);

// ===== bench/tb_json_string_escape_utf8.sv =====
// ----------------------------------------------------------------------------
// tb_json_string_escape_utf8
// Self-checking bench for the JSON string escaper. A short table of corner
// items (quotes, every escape class, UTF-8 rejects, cut-off and restarted
// strings) is followed by random strings mixing ASCII, control bytes, valid
// and broken UTF-8 sequences and noise, with random idle on both sides.
// Every output beat is checked against a typed result or an escaper model held in the bench.
// ----------------------------------------------------------------------------
module tb_json_string_escape_utf8;
    timeunit 1ns;
    timeprecision 1ps;

    import jse_pkg::*;

    // Escape letters and the control bytes that map onto them
    localparam logic [7:0] CH_LC_B = 8'h62;
    localparam logic [7:0] CH_LC_F = 8'h66;
    localparam logic [7:0] CH_LC_N = 8'h6E;
    localparam logic [7:0] CH_LC_R = 8'h72;
    localparam logic [7:0] CH_LC_T = 8'h74;
    localparam logic [7:0] B_BS    = 8'h08;
    localparam logic [7:0] B_FF    = 8'h0C;
    localparam logic [7:0] B_LF    = 8'h0A;
    localparam logic [7:0] B_CR    = 8'h0D;
    localparam logic [7:0] B_TAB   = 8'h09;
    localparam logic [7:0] CTRL_END  = 8'h20;
    localparam logic [7:0] ASCII_END = 8'h80;

    // UTF-8 lead and continuation limits
    localparam logic [7:0] U_CONT      = 8'h80;
    localparam logic [7:0] U_CONT_MASK = 8'hC0;
    localparam logic [7:0] U_LEAD2     = 8'hC2;
    localparam logic [7:0] U_LEAD3     = 8'hE0;
    localparam logic [7:0] U_LEAD4     = 8'hF0;
    localparam logic [7:0] U_LEAD_END  = 8'hF5;
    localparam logic [7:0] U_SURR_LEAD = 8'hED;
    localparam logic [7:0] U_MAX_LEAD  = 8'hF4;
    localparam logic [7:0] U_SEC_A0    = 8'hA0;
    localparam logic [7:0] U_SEC_90    = 8'h90;

    localparam int MAX_CHARS    = 25;
    localparam int DRAIN_CYCLES = 40;
    localparam int RAND_ITEMS   = 400;
    localparam int PAUSE_EVERY  = 100;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_json_char;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic [7:0] i_s_tdata  = 8'h00;   // [7:0] in_byte
    logic [1:0] i_s_tuser  = 2'b00;   // [0] has_byte, [1] first_item
    logic       i_s_tlast  = 1'b0;    // last_item
    logic       i_m_tready = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;            // [7:0] out_char
    logic       o_m_tlast;            // last_char

    // Escaper model state and the characters it still expects
    t_json_char  json_chars_q[$];
    logic [7:0]  item_chars[$];
    string       typed_q[$];
    logic [7:0]  utf_hold[3];
    int unsigned utf_held = 0;
    int unsigned utf_len  = 0;

    logic [7:0]  str_bytes[$];
    t_item       corner_items[$];
    string       corner_want[$];
    bit          idling = 1'b1;
    int unsigned stall_left = 0;
    int          errors = 0;
    int          items_sent = 0;
    int          items_in = 0;
    int          chars_out = 0;

    json_string_escape_utf8 DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Escaper model
    // ------------------------------------------------------------------------
    function automatic void put_char(logic [7:0] c);
        if (item_chars.size() < MAX_CHARS) item_chars.push_back(c);
    endfunction

    function automatic void put_hex(logic [7:0] b);
        string digits;
        digits = "0123456789abcdef";
        put_char(CH_BSLASH);
        put_char(CH_U);
        put_char(CH_ZERO);
        put_char(CH_ZERO);
        put_char(digits[b[7:4]]);
        put_char(digits[b[3:0]]);
    endfunction

    function automatic void flush_held();
        for (int k = 0; k < utf_held; k++) put_hex(utf_hold[k]);
        utf_held = 0;
        utf_len  = 0;
    endfunction

    // byte with no sequence open
    function automatic void escape_fresh(logic [7:0] b);
        logic [7:0] letter;
        letter = 8'h00;
        case (b)
            CH_QUOTE:  letter = CH_QUOTE;
            CH_BSLASH: letter = CH_BSLASH;
            B_BS:      letter = CH_LC_B;
            B_FF:      letter = CH_LC_F;
            B_LF:      letter = CH_LC_N;
            B_CR:      letter = CH_LC_R;
            B_TAB:     letter = CH_LC_T;
            default:   ;
        endcase
        if (letter != 8'h00) begin
            put_char(CH_BSLASH);
            put_char(letter);
        end else if (b < CTRL_END) begin
            put_hex(b);
        end else if (b < ASCII_END) begin
            put_char(b);
        end else if (b >= U_LEAD2 && b < U_LEAD_END) begin
            utf_hold[0] = b;
            utf_held    = 1;
            utf_len     = (b < U_LEAD3) ? 2 : ((b < U_LEAD4) ? 3 : 4);
        end else begin
            put_hex(b);
        end
    endfunction

    // second byte limits reject overlongs, surrogates and > U+10FFFF
    function automatic bit utf_fits(logic [7:0] b);
        logic [7:0] lead;
        lead = utf_hold[0];
        if ((b & U_CONT_MASK) != U_CONT) return 1'b0;
        if (utf_held == 1) begin
            if (lead == U_LEAD3 && b < U_SEC_A0) return 1'b0;
            if (lead == U_SURR_LEAD && b >= U_SEC_A0) return 1'b0;
            if (lead == U_LEAD4 && b < U_SEC_90) return 1'b0;
            if (lead == U_MAX_LEAD && b >= U_SEC_90) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void take_byte(logic [7:0] b);
        if (utf_held == 0) begin
            escape_fresh(b);
        end else if (!utf_fits(b)) begin
            flush_held();
            escape_fresh(b);
        end else if (utf_held + 1 >= utf_len) begin
            for (int k = 0; k < utf_held; k++) put_char(utf_hold[k]);
            put_char(b);
            utf_held = 0;
            utf_len  = 0;
        end else begin
            utf_hold[utf_held] = b;
            utf_held++;
        end
    endfunction

    // expected characters of one item; a typed string overrides the model
    function automatic void escape_item(t_item it, string typed);
        item_chars.delete();
        if (it.first_item) begin
            utf_held = 0;
            utf_len  = 0;
            put_char(CH_QUOTE);
        end
        if (it.has_byte) take_byte(it.in_byte);
        if (it.last_item) begin
            flush_held();
            put_char(CH_QUOTE);
        end
        if (typed.len() != 0) begin
            item_chars.delete();
            for (int k = 0; k < typed.len(); k++) item_chars.push_back(typed[k]);
        end
        foreach (item_chars[k])
            json_chars_q.push_back('{item_chars[k], k == item_chars.size() - 1});
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: predict on input beats, check output beats
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_item      acc;
        t_json_char want;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                acc.in_byte    = i_s_tdata;
                acc.has_byte   = i_s_tuser[0];
                acc.first_item = i_s_tuser[1];
                acc.last_item  = i_s_tlast;
                escape_item(acc, typed_q.pop_front());
                items_in++;
            end
            if (o_m_tvalid && i_m_tready) begin
                chars_out++;
                if (json_chars_q.size() == 0) begin
                    $error("unexpected beat: out_char %h last_char %b", o_m_tdata, o_m_tlast);
                    errors++;
                end else begin
                    want = json_chars_q.pop_front();
                    if (o_m_tdata !== want.ch) begin
                        $error("out_char: expected %h, got %h", want.ch, o_m_tdata);
                        errors++;
                    end
                    if (o_m_tlast !== want.last) begin
                        $error("last_char: expected %b, got %b", want.last, o_m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

    // Receiver: random stall after each accepted beat, only while idling is set
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            stall_left = idling ? $urandom_range(0, 3) : 0;
        end else if (!i_m_tready && stall_left != 0) begin
            stall_left--;
        end
        i_m_tready <= i_rst_n && (stall_left == 0);
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_item mk_item(logic [7:0] b, bit has, bit first, bit last);
        t_item it;
        it.in_byte    = b;
        it.has_byte   = has;
        it.first_item = first;
        it.last_item  = last;
        return it;
    endfunction

    function automatic void corner(logic [7:0] b, bit has, bit first, bit last, string want);
        corner_items.push_back(mk_item(b, has, first, last));
        corner_want.push_back(want);
    endfunction

    task automatic send_item(t_item it, string typed);
        int gap;
        gap = idling ? $urandom_range(0, 3) : 0;
        typed_q.push_back(typed);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= it.in_byte;
        i_s_tuser  <= {it.first_item, it.has_byte};
        i_s_tlast  <= it.last_item;
        do @(posedge i_clk); while (!o_s_tready);
        items_sent++;
    endtask

    // hold the input until every expected character has left
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (json_chars_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one UTF-8 sequence, valid or broken (cut short or a byte replaced)
    function automatic void gen_utf8(bit broken);
        int         len;
        logic [7:0] seq[4];
        len = $urandom_range(2, 4);
        for (int k = 1; k < 4; k++) begin
            seq[k] = 8'($urandom_range(8'h80, 8'hBF));
            if (k >= 2 && $urandom_range(0, 3) == 0) seq[k] = $urandom_range(0, 1) ? 8'hBF : 8'h80;
        end
        case (len)
            2: seq[0] = 8'($urandom_range(8'hC2, 8'hDF));
            3: begin
                seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
                if (seq[0] == U_LEAD3) seq[1] = 8'($urandom_range(8'hA0, 8'hBF));
                if (seq[0] == U_SURR_LEAD) seq[1] = 8'($urandom_range(8'h80, 8'h9F));
            end
            default: begin
                seq[0] = 8'($urandom_range(8'hF0, 8'hF4));
                if (seq[0] == U_LEAD4) seq[1] = 8'($urandom_range(8'h90, 8'hBF));
                if (seq[0] == U_MAX_LEAD) seq[1] = 8'($urandom_range(8'h80, 8'h8F));
            end
        endcase
        if (broken) begin
            if ($urandom_range(0, 1)) len = $urandom_range(1, len - 1);
            else seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
        end
        for (int k = 0; k < len; k++) str_bytes.push_back(seq[k]);
    endfunction

    // one random string: bytes, odd empty items, closed on a byte, apart or not at all
    task automatic send_string();
        int  nchunks;
        int  pick;
        bit  opened;
        bit  apart;
        bit  unclosed;
        bit  last;
        str_bytes.delete();
        opened   = 1'b0;
        nchunks  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        repeat (nchunks) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                str_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
            end else if (pick < 45) begin
                case ($urandom_range(0, 3))
                    0, 1:    str_bytes.push_back(8'($urandom_range(0, 31)));
                    2:       str_bytes.push_back(CH_QUOTE);
                    default: str_bytes.push_back(CH_BSLASH);
                endcase
            end else if (pick < 75) begin
                gen_utf8(1'b0);
            end else if (pick < 90) begin
                gen_utf8(1'b1);
            end else begin
                str_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        apart    = (str_bytes.size() == 0) || ($urandom_range(0, 3) == 0);
        unclosed = ($urandom_range(0, 9) == 0);
        foreach (str_bytes[k]) begin
            if ($urandom_range(0, 19) == 0) begin
                send_item(mk_item(8'($urandom_range(0, 255)), 1'b0, !opened, 1'b0), "");
                opened = 1'b1;
            end
            last = !apart && !unclosed && (k == str_bytes.size() - 1);
            send_item(mk_item(str_bytes[k], 1'b1, !opened, last), "");
            opened = 1'b1;
        end
        if (apart && !unclosed)
            send_item(mk_item(8'($urandom_range(0, 255)), 1'b0, !opened, 1'b1), "");
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int next_pause;
        int n_corner;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corner table: byte, has_byte, first, last, typed result or model
        corner(8'h00, 1'b0, 1'b1, 1'b1, "\"\"");
        corner(8'h00, 1'b1, 1'b1, 1'b0, "\"\\u0000");
        corner(8'h22, 1'b1, 1'b0, 1'b0, "\\\"");
        corner(8'h5C, 1'b1, 1'b0, 1'b0, "\\\\");
        corner(8'h08, 1'b1, 1'b0, 1'b0, "\\b");
        corner(8'h0C, 1'b1, 1'b0, 1'b0, "\\f");
        corner(8'h0A, 1'b1, 1'b0, 1'b0, "\\n");
        corner(8'h0D, 1'b1, 1'b0, 1'b0, "\\r");
        corner(8'h09, 1'b1, 1'b0, 1'b0, "\\t");
        corner(8'h1F, 1'b1, 1'b0, 1'b0, "\\u001f");
        corner(8'h7F, 1'b1, 1'b0, 1'b0, "");
        corner(8'hFF, 1'b1, 1'b0, 1'b0, "\\u00ff");
        corner(8'h80, 1'b1, 1'b0, 1'b0, "\\u0080");
        corner(8'hC2, 1'b1, 1'b0, 1'b0, "");
        corner(8'hBF, 1'b1, 1'b0, 1'b0, "");
        corner(8'hE0, 1'b1, 1'b0, 1'b0, "");
        corner(8'h9F, 1'b1, 1'b0, 1'b0, "\\u00e0\\u009f");
        corner(8'hED, 1'b1, 1'b0, 1'b0, "");
        corner(8'hA0, 1'b1, 1'b0, 1'b0, "\\u00ed\\u00a0");
        corner(8'hF0, 1'b1, 1'b0, 1'b0, "");
        corner(8'h9F, 1'b1, 1'b0, 1'b0, "");
        corner(8'h80, 1'b1, 1'b0, 1'b0, "");
        corner(8'hBF, 1'b1, 1'b0, 1'b1, "");
        corner(8'hE2, 1'b1, 1'b1, 1'b0, "\"");
        corner(8'h82, 1'b1, 1'b0, 1'b0, "");
        corner(8'h00, 1'b0, 1'b0, 1'b1, "\\u00e2\\u0082\"");
        corner(8'hF1, 1'b1, 1'b0, 1'b0, "");
        corner(8'h41, 1'b1, 1'b1, 1'b1, "\"A\"");

        n_corner = corner_items.size();
        foreach (corner_items[k]) send_item(corner_items[k], corner_want[k]);
        wait_idle();

        // random strings, with a full drain now and then
        next_pause = items_sent + PAUSE_EVERY;
        while (items_sent < n_corner + RAND_ITEMS) begin
            idling = ($urandom_range(0, 4) != 0);
            send_string();
            if (items_sent >= next_pause) begin
                wait_idle();
                next_pause = items_sent + PAUSE_EVERY;
            end
        end
        wait_idle();

        if (json_chars_q.size() != 0) begin
            $error("%0d expected characters never arrived", json_chars_q.size());
            errors++;
        end
        $display("Run: %0d items (%0d corner rows), %0d characters checked, %0d mismatches",
                 items_in, n_corner, chars_out, errors);
        $display("Covered escape classes, valid and broken UTF-8, cut-off strings, idle gaps");
        if (errors == 0) begin
            $display("[json_string_escape_utf8] OK");
        end else begin
            $display("[json_string_escape_utf8] ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("[json_string_escape_utf8] ERROR");
        $finish;
    end

endmodule
